### src/assert_macros.svh
// Assertion macros shared by the RGB median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define RMF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define RMF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RMF_ASSERT(label, clk, rst_n, prop, msg)
`define RMF_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### src/rmf_pkg.sv
// Types, constants and compare helpers for the RGB 3x3 median filter.
package rmf_pkg;

  localparam int CH_W         = 8;
  localparam int ROW_W        = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int WIN_DIM      = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Register reset values and the smallest usable image dimension.
  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
  localparam logic [CFG_DATA_W-1:0] MIN_DIM          = 12'd2;

  // Input beat kinds.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  localparam pix_t PIX_MIN = '{red: '0, green: '0, blue: '0};
  localparam pix_t PIX_MAX = '{red: '1, green: '1, blue: '1};

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            end_of_row;
    logic            end_of_image;
  } out_beat_t;

  function automatic logic [CH_W-1:0] ch_min(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CH_W-1:0] ch_max(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  // Channel-wise minimum and maximum of two pixels.
  function automatic pix_t pix_min(pix_t a, pix_t b);
    pix_t r;
    r.red   = ch_min(a.red, b.red);
    r.green = ch_min(a.green, b.green);
    r.blue  = ch_min(a.blue, b.blue);
    return r;
  endfunction

  function automatic pix_t pix_max(pix_t a, pix_t b);
    pix_t r;
    r.red   = ch_max(a.red, b.red);
    r.green = ch_max(a.green, b.green);
    r.blue  = ch_max(a.blue, b.blue);
    return r;
  endfunction

  function automatic pix_t pix_min3(pix_t a, pix_t b, pix_t c);
    return pix_min(pix_min(a, b), c);
  endfunction

  function automatic pix_t pix_max3(pix_t a, pix_t b, pix_t c);
    return pix_max(pix_max(a, b), c);
  endfunction

  // Channel-wise median of three pixels.
  function automatic pix_t pix_med3(pix_t a, pix_t b, pix_t c);
    return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
  endfunction

endpackage

### src/rgb_median_filter_3x3_core.sv
// Streaming RGB 3x3 median filter: line store, window, median pipeline.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | pixel or drain tick
//   output  | out_valid, out_stall, out_data | filtered pixel and row flags
//   config  | cfg_we, cfg_index, cfg_wdata   | image width or height write
//
// One input beat is taken per clock while in_stall is low. A pixel that closes a row (from the second
// row on) gives two results, and the window stage then holds the input
// while its second result goes out through the single median unit.
// A result passes the window stage, job register, row-sorted stage and output register.
// Reset is synchronous; the line store is not cleared and needs no clearing pass.
// A stall on the output backs up through the stages; bubbles keep input flowing.
`include "assert_macros.svh"

module rgb_median_filter_3x3_core #(
  parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rmf_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rmf_pkg::out_beat_t                 out_data,
  input  logic                               cfg_we,
  input  logic [rmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int LW   = (CW + 1 > rmf_pkg::CFG_DATA_W) ? CW + 1 : rmf_pkg::CFG_DATA_W;
  localparam int RW   = rmf_pkg::ROW_W;
  localparam int DIM  = rmf_pkg::WIN_DIM;
  localparam int PX_W = $bits(rmf_pkg::pix_t);

  // Control carried by a beat in the window stage.
  typedef struct packed {
    logic          drain;
    logic          emit_one;
    logic          emit_two;
    logic          row_miss;
    logic          col_miss;
    logic          first_col;
    logic          drain_first;
    logic          drain_last;
    logic [CW-1:0] col;
  } bctl_t;

  // Configuration and position counters.
  logic [rmf_pkg::CFG_DATA_W-1:0] width_r, height_r;
  logic [CW-1:0]                  col_r, col_nxt;
  logic [RW-1:0]                  row_r, row_nxt;
  logic [CW-1:0]                  drain_r, drain_nxt;
  logic [CW:0]                    drain_inc;

  logic [LW-1:0] w_ext, w_clamp;
  logic [CW-1:0] last_col;
  logic [RW-1:0] h_eff, last_row;
  logic          draining;
  logic          cfg_hit;

  logic        in_acc, a_pix, a_drn, a_ready, k_last;
  bctl_t       a_ctl;
  rmf_pkg::pix_t in_pix;

  // Window stage.
  logic          b_valid_r;
  bctl_t         b_ctl_r;
  rmf_pkg::pix_t b_pix_r;
  logic          b_has_job, b_fire;

  // Line store: previous row and the row before it, side by side.
  logic [CW-1:0]     rd_addr;
  logic [2*PX_W-1:0] rd_data, wr_data;
  logic              wr_en;
  rmf_pkg::pix_t     rd_prev, rd_prev2;

  rmf_pkg::pix_t win_r   [DIM][DIM];
  rmf_pkg::pix_t win_nxt [DIM][DIM];
  rmf_pkg::pix_t first_top_r, first_bot_r;

  // Second result of a row-closing pixel.
  logic pend_r, pend_row_miss_r, pend_fire;

  // Median job.
  rmf_pkg::pix_t src     [DIM][DIM];
  rmf_pkg::pix_t job_nxt [DIM][DIM];
  logic          job_row_miss, job_col_miss, job_shift, job_eor, job_eoi;
  logic          j_valid_r, j_ready, j_load;
  rmf_pkg::pix_t j_cell_r [DIM][DIM];
  logic          j_eor_r, j_eoi_r;

  // Row-sorted stage.
  logic          k_valid_r, k_ready;
  rmf_pkg::pix_t k_lo_r [DIM];
  rmf_pkg::pix_t k_mid_r [DIM];
  rmf_pkg::pix_t k_hi_r [DIM];
  logic          k_eor_r, k_eoi_r;

  // Output register.
  logic               out_valid_r, out_ready;
  rmf_pkg::out_beat_t out_data_r;
  rmf_pkg::pix_t      med_nxt;

  // Effective image size after clamping.
  always_comb begin
    w_ext = LW'(width_r);
    if (w_ext > LW'(MAX_WIDTH)) begin
      w_clamp = LW'(MAX_WIDTH);
    end else if (w_ext < LW'(rmf_pkg::MIN_DIM)) begin
      w_clamp = LW'(rmf_pkg::MIN_DIM);
    end else begin
      w_clamp = w_ext;
    end
    last_col = CW'(w_clamp - LW'(1));
    h_eff    = (height_r < rmf_pkg::MIN_DIM) ? RW'(rmf_pkg::MIN_DIM) : RW'(height_r);
    last_row = h_eff - RW'(1);
  end

  assign draining  = (row_r >= h_eff);
  assign cfg_hit   = cfg_we && ((cfg_index == rmf_pkg::CFG_IMAGE_WIDTH) ||
                                (cfg_index == rmf_pkg::CFG_IMAGE_HEIGHT));
  assign drain_inc = {1'b0, drain_r} + {{CW{1'b0}}, 1'b1};
  assign k_last    = (drain_r == last_col);

  // Input decode: stray pixels while draining and stray drain ticks are dropped.
  assign in_acc   = in_valid && !in_stall;
  assign a_pix    = in_acc && !draining && (in_data.req_type == rmf_pkg::REQ_PIXEL);
  assign a_drn    = in_acc && draining && (in_data.req_type == rmf_pkg::REQ_DRAIN);
  assign in_pix   = '{red: in_data.in_red, green: in_data.in_green, blue: in_data.in_blue};
  assign in_stall = !a_ready;

  always_comb begin
    a_ctl             = '0;
    a_ctl.drain       = draining;
    a_ctl.emit_one    = (row_r != '0) && (col_r != '0);
    a_ctl.emit_two    = (row_r != '0) && (col_r == last_col);
    a_ctl.row_miss    = (row_r == RW'(1));
    a_ctl.col_miss    = (col_r == CW'(1));
    a_ctl.first_col   = (row_r == last_row) && (col_r == '0);
    a_ctl.drain_first = (drain_r == '0);
    a_ctl.drain_last  = k_last;
    a_ctl.col         = col_r;
  end

  // Counter update; a write to the width or height register restarts the image.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    if (cfg_hit) begin
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = '0;
    end else if (a_drn) begin
      if (k_last) begin
        col_nxt   = '0;
        row_nxt   = '0;
        drain_nxt = '0;
      end else begin
        drain_nxt = drain_inc[CW-1:0];
      end
    end else if (a_pix) begin
      if (col_r == last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rmf_pkg::IMAGE_WIDTH_RST;
      height_r <= rmf_pkg::IMAGE_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      drain_r  <= '0;
    end else begin
      if (cfg_we && (cfg_index == rmf_pkg::CFG_IMAGE_WIDTH)) begin
        width_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == rmf_pkg::CFG_IMAGE_HEIGHT)) begin
        height_r <= cfg_wdata;
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
    end
  end

  // Line store read: a pixel fetches its own column, a drain tick the next one.
  assign rd_addr = a_drn ? drain_inc[CW-1:0] : col_r;

  rmf_ram #(
    .DATA_W (2 * PX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b_ctl_r.col),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_prev2 = rmf_pkg::pix_t'(rd_data[2*PX_W-1:PX_W]);
  assign rd_prev  = rmf_pkg::pix_t'(rd_data[PX_W-1:0]);
  assign wr_en    = b_fire && !b_ctl_r.drain;
  assign wr_data  = {rd_prev, b_pix_r};

  // Window stage handshake.
  assign b_has_job = b_ctl_r.drain || b_ctl_r.emit_one;
  assign b_fire    = b_valid_r && !pend_r && (j_ready || !b_has_job);
  assign a_ready   = !b_valid_r || b_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_pix || a_drn;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      b_ctl_r <= a_ctl;
      b_pix_r <= in_pix;
    end
  end

  // Window shift: a new column enters on the right.
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    if (b_ctl_r.drain) begin
      win_nxt[0][2] = rd_prev2;
      win_nxt[1][2] = rd_prev2;
      win_nxt[2][2] = rd_prev;
      if (b_ctl_r.drain_first) begin
        win_nxt[1][1] = first_top_r;
        win_nxt[2][1] = first_bot_r;
      end
    end else begin
      win_nxt[0][2] = rd_prev2;
      win_nxt[1][2] = rd_prev;
      win_nxt[2][2] = b_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          win_r[i][j] <= win_nxt[i][j];
        end
      end
      // The first column of the last row is kept for the drain pass.
      if (!b_ctl_r.drain && b_ctl_r.first_col) begin
        first_top_r <= rd_prev;
        first_bot_r <= b_pix_r;
      end
    end
  end

  // Job selection. Missing cells sit in the top row and left column and are
  // padded with extremes so that the middle of nine is the wanted element.
  always_comb begin
    job_row_miss = 1'b0;
    job_col_miss = 1'b0;
    job_shift    = 1'b0;
    job_eor      = 1'b0;
    job_eoi      = 1'b0;
    if (pend_r) begin
      job_row_miss = pend_row_miss_r;
      job_col_miss = 1'b1;
      job_eor      = 1'b1;
    end else if (b_ctl_r.drain) begin
      job_row_miss = 1'b1;
      job_col_miss = b_ctl_r.drain_first || b_ctl_r.drain_last;
      job_shift    = b_ctl_r.drain_last;
      job_eor      = b_ctl_r.drain_last;
      job_eoi      = b_ctl_r.drain_last;
    end else begin
      job_row_miss = b_ctl_r.row_miss;
      job_col_miss = b_ctl_r.col_miss;
    end
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        src[i][j] = pend_r ? win_r[i][j] : win_nxt[i][j];
      end
    end
    for (int i = 0; i < DIM; i++) begin
      job_nxt[i][0] = src[i][0];
      job_nxt[i][1] = job_shift ? src[i][0] : src[i][1];
      job_nxt[i][2] = job_shift ? src[i][1] : src[i][2];
    end
    if (job_row_miss || job_col_miss) begin
      job_nxt[0][0] = job_row_miss ? rmf_pkg::PIX_MIN : rmf_pkg::PIX_MAX;
    end
    if (job_row_miss) begin
      job_nxt[0][1] = rmf_pkg::PIX_MAX;
      job_nxt[0][2] = rmf_pkg::PIX_MAX;
    end
    if (job_col_miss) begin
      job_nxt[1][0] = rmf_pkg::PIX_MIN;
      job_nxt[2][0] = rmf_pkg::PIX_MAX;
    end
  end

  assign pend_fire = pend_r && j_ready;
  assign j_load    = pend_fire || (b_fire && b_has_job);
  assign j_ready   = !j_valid_r || k_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      j_valid_r <= 1'b0;
    end else begin
      if (pend_fire) begin
        pend_r <= 1'b0;
      end else if (b_fire && !b_ctl_r.drain && b_ctl_r.emit_two) begin
        pend_r <= 1'b1;
      end
      if (j_ready) begin
        j_valid_r <= j_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      pend_row_miss_r <= b_ctl_r.row_miss;
    end
    if (j_load) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          j_cell_r[i][j] <= job_nxt[i][j];
        end
      end
      j_eor_r <= job_eor;
      j_eoi_r <= job_eoi;
    end
  end

  // Median, first half: sort each window row.
  assign k_ready = !k_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_valid_r <= 1'b0;
    end else if (k_ready) begin
      k_valid_r <= j_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (k_ready) begin
      for (int i = 0; i < DIM; i++) begin
        k_lo_r[i]  <= rmf_pkg::pix_min3(j_cell_r[i][0], j_cell_r[i][1], j_cell_r[i][2]);
        k_mid_r[i] <= rmf_pkg::pix_med3(j_cell_r[i][0], j_cell_r[i][1], j_cell_r[i][2]);
        k_hi_r[i]  <= rmf_pkg::pix_max3(j_cell_r[i][0], j_cell_r[i][1], j_cell_r[i][2]);
      end
      k_eor_r <= j_eor_r;
      k_eoi_r <= j_eoi_r;
    end
  end

  // Median, second half: largest low, middle middle, smallest high.
  assign med_nxt = rmf_pkg::pix_med3(rmf_pkg::pix_max3(k_lo_r[0], k_lo_r[1], k_lo_r[2]),
                                     rmf_pkg::pix_med3(k_mid_r[0], k_mid_r[1], k_mid_r[2]),
                                     rmf_pkg::pix_min3(k_hi_r[0], k_hi_r[1], k_hi_r[2]));

  assign out_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= k_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data_r.out_red      <= med_nxt.red;
      out_data_r.out_green    <= med_nxt.green;
      out_data_r.out_blue     <= med_nxt.blue;
      out_data_r.end_of_row   <= k_eor_r;
      out_data_r.end_of_image <= k_eoi_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A pending second result always has its first one in the job register.
  `RMF_ASSERT(a_pend_after_job, clk, rst_n, pend_r |-> j_valid_r, "pending result without job")
  // The image end is always also a row end.
  `RMF_ASSERT(a_eoi_is_eor, clk, rst_n, (out_valid && out_data.end_of_image) |-> out_data.end_of_row, "end of image without end of row")
  // The drain count only moves while the last row is being flushed.
  `RMF_ASSERT(a_drain_only_flushing, clk, rst_n, (drain_r != '0) |-> draining, "drain count moved outside drain")
  // The column counter stays inside the row.
  `RMF_ASSERT_NEVER(a_col_in_row, clk, rst_n, col_r > last_col, "column counter beyond last column")

endmodule

### src/rmf_ram.sv
// Generic single-write, single-read RAM with registered, write-first read.
module rmf_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // A read of the address written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule
